// ===== rtl/usbdf_pkg.sv =====
`default_nettype none

package usbdf_pkg;

  localparam int unsigned PacketBytes = 30;
  localparam int unsigned PacketWords = 8;
  localparam int unsigned PadBytes    = PacketWords * 4;
  localparam int unsigned MagicLen    = 22;
  localparam int unsigned FillW       = $clog2(PadBytes);
  localparam int unsigned WordIdxW    = $clog2(PacketWords);
  localparam int unsigned RecentW     = $clog2(MagicLen + 1);
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QPtrW       = $clog2(QueueDepth);
  localparam int unsigned QCntW       = $clog2(QueueDepth + 1);

  // index 0 is the oldest byte of the window
  localparam logic [MagicLen-1:0][7:0] MagicSeq = {
    {11{8'h21}},
    8'h4c, 8'h45, 8'h53, 8'h54, 8'h4f, 8'h4f, 8'h42, 8'h34, 8'h36, 8'h43, 8'h50
  };

  typedef enum logic {
    KindWord = 1'b0,
    KindBoot = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                             kind;
    logic [PacketWords-1:0][31:0]      words;
    logic [31:0]                       seq;
  } entry_t;

  // Reordered position of a packet byte; the mapping is its own inverse.
  function automatic logic [FillW-1:0] perm_pos(input logic [FillW-1:0] p);
    logic [FillW-1:0] r;
    r = p;
    if (p >= FillW'(4) && p < FillW'(16)) begin
      r = {p[FillW-1:2], ~p[1:0]};
    end else if (p >= FillW'(16) && p < FillW'(26)) begin
      r = p ^ FillW'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/usbdf_front.sv =====
`default_nettype none

module usbdf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          rx_byte_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                push_o,
  input  logic                push_ready_i,
  output usbdf_pkg::entry_t   entry_o
);
  import usbdf_pkg::*;

  logic [PadBytes-1:0][7:0] asm_q, asm_d;
  logic [FillW-1:0]         fill_q, fill_d;
  logic [MagicLen-1:0][7:0] recent_q, recent_d;
  logic [RecentW-1:0]       rcnt_q, rcnt_d;
  logic [31:0]              seq_q, seq_d;
  logic [MagicLen-1:0][7:0] window;
  logic                     accept, magic_hit, pkt_done;
  logic [PadBytes-1:0][7:0] padded;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign window    = {rx_byte_i, recent_q[MagicLen-1:1]};
  assign magic_hit = (rcnt_q >= RecentW'(MagicLen - 1)) && (window == MagicSeq);
  assign pkt_done  = (fill_q == FillW'(PacketBytes - 1));

  always_comb begin
    asm_d = asm_q;
    asm_d[perm_pos(fill_q)] = rx_byte_i;
    for (int unsigned i = 0; i < PadBytes; i++) begin
      padded[i] = (i >= PacketBytes) ? 8'h00 : asm_d[i];
    end
  end

  always_comb begin
    entry_o.kind  = magic_hit ? KindBoot : KindWord;
    entry_o.seq   = seq_q + 32'd1;
    for (int unsigned w = 0; w < PacketWords; w++) begin
      entry_o.words[w] = {padded[4*w], padded[4*w+1], padded[4*w+2], padded[4*w+3]};
    end
  end

  assign push_o = accept && (magic_hit || pkt_done);

  always_comb begin
    fill_d   = fill_q;
    recent_d = recent_q;
    rcnt_d   = rcnt_q;
    seq_d    = seq_q;
    if (accept) begin
      if (magic_hit) begin
        fill_d   = '0;
        recent_d = '0;
        rcnt_d   = '0;
        seq_d    = '0;
      end else begin
        recent_d = window;
        if (rcnt_q < RecentW'(MagicLen)) begin
          rcnt_d = rcnt_q + RecentW'(1);
        end
        if (pkt_done) begin
          fill_d = '0;
          seq_d  = seq_q + 32'd1;
        end else begin
          fill_d = fill_q + FillW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      recent_q <= '0;
      rcnt_q   <= '0;
      seq_q    <= '0;
    end else begin
      fill_q   <= fill_d;
      recent_q <= recent_d;
      rcnt_q   <= rcnt_d;
      seq_q    <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      asm_q <= asm_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/usbdf_queue.sv =====
`default_nettype none

module usbdf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                push_ready_o,
  input  usbdf_pkg::entry_t   entry_i,
  output logic                head_valid_o,
  output usbdf_pkg::entry_t   head_o,
  input  logic                pop_i
);
  import usbdf_pkg::*;

  entry_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]   wr_q, rd_q;
  logic [QCntW-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign push_ready_o = (cnt_q != QCntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/usbdf_back.sv =====
`default_nettype none

module usbdf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  usbdf_pkg::entry_t   head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                kind_o,
  output logic [31:0]         packet_word_o,
  output logic [2:0]          word_index_o,
  output logic                buffer_select_o,
  output logic [31:0]         packet_sequence_o,
  output logic                last_o
);
  import usbdf_pkg::*;

  logic [WordIdxW-1:0] idx_q;
  logic                vld_q;
  logic                load, is_boot, final_beat;

  assign load       = head_valid_i && (!vld_q || out_ready_i);
  assign is_boot    = (head_i.kind == KindBoot);
  assign final_beat = is_boot || (idx_q == WordIdxW'(PacketWords - 1));
  assign pop_o      = load && final_beat;
  assign out_valid_o = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        idx_q <= final_beat ? '0 : idx_q + WordIdxW'(1);
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      last_o <= final_beat;
      if (is_boot) begin
        kind_o            <= KindBoot;
        packet_word_o     <= '0;
        word_index_o      <= '0;
        buffer_select_o   <= 1'b0;
        packet_sequence_o <= '0;
      end else begin
        kind_o            <= KindWord;
        packet_word_o     <= head_i.words[idx_q];
        word_index_o      <= 3'(idx_q);
        buffer_select_o   <= head_i.seq[0];
        packet_sequence_o <= head_i.seq;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/usb_packet_deframer_with_magic_detect.sv =====
`default_nettype none

// Channel   Handshake                  Beat
// in        in_valid_i / in_ready_o    rx_byte_i
// out       out_valid_o / out_ready_i  kind_o, packet_word_o, word_index_o,
//                                      buffer_select_o, packet_sequence_o, last_o
//
// One byte per cycle in while the queue has room. A finished packet leaves as
// eight beats, one per cycle while out_ready_i is high; a boot request is a
// single beat. A two-entry packet queue parts the byte side from the word side;
// input stalls only while it is full. Reset clears counts, window and sequence.

module usb_packet_deframer_with_magic_detect (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  rx_byte_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [31:0] packet_word_o,
  output logic [2:0]  word_index_o,
  output logic        buffer_select_o,
  output logic [31:0] packet_sequence_o,
  output logic        last_o
);
  import usbdf_pkg::*;

  logic   push, push_ready, head_valid, pop;
  entry_t entry, head;

  usbdf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .push_o       (push),
    .push_ready_i (push_ready),
    .entry_o      (entry)
  );

  usbdf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .entry_i      (entry),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  usbdf_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_valid_i      (head_valid),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .packet_word_o     (packet_word_o),
    .word_index_o      (word_index_o),
    .buffer_select_o   (buffer_select_o),
    .packet_sequence_o (packet_sequence_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

// ===== tb/usb_packet_deframer_with_magic_detect_tb.sv =====
module usb_packet_deframer_with_magic_detect_tb;
  import usbdf_pkg::*;

  typedef struct {
    kind_e       kind;
    logic [31:0] word;
    logic [2:0]  idx;
    logic        bsel;
    logic [31:0] seq;
    logic        last;
  } beat_t;

  localparam logic [7:0] BootKey [MagicLen] = '{
    8'h50, 8'h43, 8'h36, 8'h34, 8'h42, 8'h4f, 8'h4f, 8'h54, 8'h53, 8'h45, 8'h4c,
    8'h21, 8'h21, 8'h21, 8'h21, 8'h21, 8'h21, 8'h21, 8'h21, 8'h21, 8'h21, 8'h21
  };
  localparam int StallLimit = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [31:0] packet_word_o;
  logic [2:0]  word_index_o;
  logic        buffer_select_o;
  logic [31:0] packet_sequence_o;
  logic        last_o;

  logic [7:0]  byte_q [$];
  beat_t       expected_beats [$];

  // shadow of the deframer state
  logic [7:0]  pkt_buf [PacketBytes];
  int          pkt_fill;
  logic [7:0]  window [MagicLen];
  int          window_fill;
  logic [31:0] pkt_seq;

  int          bytes_in = 0;
  int          stall_cycles = 0;
  bit          failed = 1'b0;
  logic        quiet;

  assign quiet = (bytes_in >= 80) && (bytes_in < 140);

  always #5 clk_i = ~clk_i;

  usb_packet_deframer_with_magic_detect dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rx_byte_i         (rx_byte_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .packet_word_o     (packet_word_o),
    .word_index_o      (word_index_o),
    .buffer_select_o   (buffer_select_o),
    .packet_sequence_o (packet_sequence_o),
    .last_o            (last_o)
  );

  task automatic clear_state();
    for (int i = 0; i < PacketBytes; i++) pkt_buf[i] = 8'h00;
    for (int i = 0; i < MagicLen; i++) window[i] = 8'h00;
    pkt_fill = 0;
    window_fill = 0;
    pkt_seq = 32'd0;
  endtask

  // Shadow update for one received byte; queues the beats it produces.
  task automatic take_byte(input logic [7:0] b);
    beat_t      e;
    logic [7:0] lane [32];
    int         src;
    bit         hit;
    pkt_buf[pkt_fill] = b;
    pkt_fill++;
    for (int i = 0; i < MagicLen - 1; i++) window[i] = window[i + 1];
    window[MagicLen - 1] = b;
    if (window_fill < MagicLen) window_fill++;
    hit = (window_fill == MagicLen);
    for (int i = 0; i < MagicLen; i++) begin
      if (window[i] != BootKey[i]) hit = 1'b0;
    end
    if (hit) begin
      // boot request beats any packet ending on the same byte
      clear_state();
      e.kind = KindBoot;
      e.word = 32'd0;
      e.idx  = 3'd0;
      e.bsel = 1'b0;
      e.seq  = 32'd0;
      e.last = 1'b1;
      expected_beats.push_back(e);
    end else if (pkt_fill == PacketBytes) begin
      pkt_fill = 0;
      pkt_seq = pkt_seq + 32'd1;
      for (int p = 0; p < 32; p++) begin
        if (p >= 4 && p < 16) src = 4 * (p / 4) + 3 - (p % 4);
        else if (p >= 16 && p < 26) src = (p % 2 == 0) ? p + 1 : p - 1;
        else src = p;
        lane[p] = (p < PacketBytes) ? pkt_buf[src] : 8'h00;
      end
      for (int w = 0; w < PacketWords; w++) begin
        e.kind = KindWord;
        e.word = {lane[4 * w], lane[4 * w + 1], lane[4 * w + 2], lane[4 * w + 3]};
        e.idx  = 3'(w);
        e.bsel = pkt_seq[0];
        e.seq  = pkt_seq;
        e.last = (w == PacketWords - 1);
        expected_beats.push_back(e);
      end
    end
  endtask

  task automatic queue_key(input bit broken);
    int cut;
    int spoil;
    cut = broken && $urandom_range(1) ? $urandom_range(MagicLen - 1, 1) : MagicLen;
    spoil = (broken && cut == MagicLen) ? $urandom_range(MagicLen - 1) : -1;
    for (int i = 0; i < cut; i++) begin
      byte_q.push_back(i == spoil ? BootKey[i] ^ 8'($urandom_range(255, 1)) : BootKey[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i <= 8'h00;
    end else begin
      if (in_valid_i && in_ready_o) begin
        take_byte(rx_byte_i);
        bytes_in <= bytes_in + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (byte_q.size() != 0 && (quiet || $urandom_range(99) >= 27)) begin
          rx_byte_i <= byte_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: kind %0d word %h", kind_o, packet_word_o);
          failed = 1'b1;
        end else begin
          e = expected_beats.pop_front();
          if (kind_o !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, kind_o);
            failed = 1'b1;
          end
          if (packet_word_o !== e.word) begin
            $error("packet_word: expected %h, got %h", e.word, packet_word_o);
            failed = 1'b1;
          end
          if (word_index_o !== e.idx) begin
            $error("word_index: expected %0d, got %0d", e.idx, word_index_o);
            failed = 1'b1;
          end
          if (buffer_select_o !== e.bsel) begin
            $error("buffer_select: expected %0d, got %0d", e.bsel, buffer_select_o);
            failed = 1'b1;
          end
          if (packet_sequence_o !== e.seq) begin
            $error("packet_sequence: expected %0d, got %0d", e.seq, packet_sequence_o);
            failed = 1'b1;
          end
          if (last_o !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last_o);
            failed = 1'b1;
          end
        end
      end
      out_ready_i <= quiet || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    int n_rand;
    clear_state();
    // key lands on the 30th byte of a packet, then again straight after the reset it causes
    byte_q = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80, 8'h7f, 8'hfe};
    queue_key(1'b0);
    queue_key(1'b0);
    n_rand = 0;
    while (n_rand < 118) begin
      r = $urandom_range(99);
      if (r < 5) begin
        queue_key(1'b0);
        n_rand += MagicLen;
      end else if (r < 9) begin
        queue_key(1'b1);
        n_rand += 12;
      end else if (r < 25) begin
        byte_q.push_back(8'h21);
        n_rand++;
      end else begin
        byte_q.push_back(8'($urandom_range(255)));
        n_rand++;
      end
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (byte_q.size() != 0 || in_valid_i || expected_beats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/usbdf_pkg.sv
rtl/usbdf_front.sv
rtl/usbdf_queue.sv
rtl/usbdf_back.sv
rtl/usb_packet_deframer_with_magic_detect.sv
tb/usb_packet_deframer_with_magic_detect_tb.sv
